FILE: design/vch_pkg.sv
// ----------------------------------------------------------------------------
// vch_pkg
// Shared types and constants of the voxel count histogram.
// ----------------------------------------------------------------------------
package vch_pkg;

	localparam int COORD_W     = 24;  // signed Q8.16 coordinate
	localparam int SCALE_W     = 16;  // unsigned Q8.8 reciprocal voxel size
	localparam int INDEX_SHIFT = 24;  // fraction bits of coordinate times scale
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_XY_SCALE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_Z_SCALE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ORDER_MODE = 2'd2;

	localparam logic [SCALE_W-1:0] XY_SCALE_RESET = 16'd25600;
	localparam logic [SCALE_W-1:0] Z_SCALE_RESET  = 16'd5120;

	localparam logic KIND_POINT = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	localparam logic ORDER_ZXY = 1'b0;
	localparam logic ORDER_XYZ = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INDEX,
		ST_UPDATE,
		ST_SCAN_RD,
		ST_SCAN_CHK
	} vch_state_t;

endpackage

FILE: design/vch_ifs.sv
// ----------------------------------------------------------------------------
// vch_ifs
// Stream channels of the voxel count histogram: point/drain input, results.
// ----------------------------------------------------------------------------
interface vch_point_if import vch_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic signed [COORD_W-1:0] x_coord;
	logic signed [COORD_W-1:0] y_coord;
	logic signed [COORD_W-1:0] z_coord;

	modport source (output valid, kind, x_coord, y_coord, z_coord, input ready);
	modport sink   (input valid, kind, x_coord, y_coord, z_coord, output ready);
endinterface

interface vch_result_if #(
	parameter int XY_BITS  = 5,
	parameter int Z_BITS   = 5,
	parameter int CNT_BITS = 16
) ();
	logic                       valid;
	logic                       ready;
	logic signed [XY_BITS-1:0]  x_index;
	logic signed [XY_BITS-1:0]  y_index;
	logic signed [Z_BITS-1:0]   z_index;
	logic        [CNT_BITS-1:0] point_count;
	logic                       done_res;

	modport source (output valid, x_index, y_index, z_index, point_count, done_res,
		input ready);
	modport sink   (input valid, x_index, y_index, z_index, point_count, done_res,
		output ready);
endinterface

FILE: design/voxel_count_histogram.sv
// ----------------------------------------------------------------------------
// voxel_count_histogram
// Bins points into a dense voxel grid of saturating counters and drains the
// nonzero voxels in a selectable scan order, then an end marker.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  pt_ch    in   valid/ready   kind, x_coord, y_coord, z_coord
//  res_ch   out  valid/ready   x_index, y_index, z_index, point_count, done_res
//  cfg      in   cfg_we        cfg_index, cfg_data
//
//  A point passes the product register, then index and counter read, then
//  write back; a dropped point ends after the index step.
//  A drain scans slots from the current scan position, each a memory read
//  then a test on the single read port, until a nonzero voxel is returned
//  and cleared or the last slot yields the end marker.
//  After reset a clearing pass over all 2^(2*XY_INDEX_BITS+Z_INDEX_BITS) slots
//  zeroes the counter memory; no item is taken meanwhile.
//  Points keep flowing while a drain result waits in the output register.
// ----------------------------------------------------------------------------
module voxel_count_histogram import vch_pkg::*; #(
	parameter int XY_INDEX_BITS = 5,
	parameter int Z_INDEX_BITS  = 5,
	parameter int COUNT_BITS    = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	vch_point_if.sink             pt_ch,
	vch_result_if.source          res_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int GB = 2 * XY_INDEX_BITS + Z_INDEX_BITS;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [GB-1:0]         SLOT_LAST = {GB{1'b1}};

	vch_state_t state_q, state_d;

	logic [SCALE_W-1:0]    xy_scale_q;
	logic [SCALE_W-1:0]    z_scale_q;
	logic                  order_mode_q;
	logic [GB-1:0]         scan_q;
	logic [GB-1:0]         clr_q;
	logic [GB-1:0]         addr_q;
	logic [COUNT_BITS-1:0] dropped_q;

	logic                     out_valid_q;
	logic [XY_INDEX_BITS-1:0] out_x_q;
	logic [XY_INDEX_BITS-1:0] out_y_q;
	logic [Z_INDEX_BITS-1:0]  out_z_q;
	logic [COUNT_BITS-1:0]    out_count_q;
	logic                     out_done_q;

	logic                     pt_xfer;
	logic                     idx_load;
	logic [XY_INDEX_BITS-1:0] dig_x, dig_y;
	logic [Z_INDEX_BITS-1:0]  dig_z;
	logic                     ok_x, ok_y, ok_z;
	logic [GB-1:0]            point_slot;
	logic [GB-1:0]            scan_slot;

	logic                  rd_en;
	logic [GB-1:0]         rd_addr;
	logic [COUNT_BITS-1:0] rd_data;
	logic                  wr_en;
	logic [GB-1:0]         wr_addr;
	logic [COUNT_BITS-1:0] wr_data;

	logic out_free;
	logic out_load;
	logic out_done;
	logic addr_load;
	logic drop_inc;
	logic scan_adv;
	logic scan_zero;
	logic clr_adv;

	assign pt_xfer  = pt_ch.valid && pt_ch.ready;
	assign idx_load = pt_xfer && (pt_ch.kind == KIND_POINT);
	assign out_free = !out_valid_q || res_ch.ready;

	vch_index #(.BITS(XY_INDEX_BITS)) u_index_x (
		.clk(clk), .load(idx_load), .coord(pt_ch.x_coord), .scale(xy_scale_q),
		.digit(dig_x), .ok(ok_x)
	);
	vch_index #(.BITS(XY_INDEX_BITS)) u_index_y (
		.clk(clk), .load(idx_load), .coord(pt_ch.y_coord), .scale(xy_scale_q),
		.digit(dig_y), .ok(ok_y)
	);
	vch_index #(.BITS(Z_INDEX_BITS)) u_index_z (
		.clk(clk), .load(idx_load), .coord(pt_ch.z_coord), .scale(z_scale_q),
		.digit(dig_z), .ok(ok_z)
	);

	vch_store #(.AW(GB), .DW(COUNT_BITS)) u_store (
		.clk(clk), .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
		.wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
	);

	assign point_slot = {dig_z, dig_x, dig_y};

	// column order reads the scan position as x, y, z digits
	always_comb begin
		if (order_mode_q == ORDER_XYZ) begin
			scan_slot = {scan_q[Z_INDEX_BITS-1:0],
				scan_q[GB-1 -: XY_INDEX_BITS],
				scan_q[Z_INDEX_BITS +: XY_INDEX_BITS]};
		end else begin
			scan_slot = scan_q;
		end
	end

	always_comb begin
		state_d     = state_q;
		pt_ch.ready = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = point_slot;
		wr_en       = 1'b0;
		wr_addr     = addr_q;
		wr_data     = '0;
		out_load    = 1'b0;
		out_done    = 1'b0;
		addr_load   = 1'b0;
		drop_inc    = 1'b0;
		scan_adv    = 1'b0;
		scan_zero   = 1'b0;
		clr_adv     = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				clr_adv = 1'b1;
				if (clr_q == SLOT_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				pt_ch.ready = 1'b1;
				if (pt_xfer) begin
					state_d = (pt_ch.kind == KIND_DRAIN) ? ST_SCAN_RD : ST_INDEX;
				end
			end
			ST_INDEX: begin
				if (ok_x && ok_y && ok_z) begin
					rd_en     = 1'b1;
					addr_load = 1'b1;
					state_d   = ST_UPDATE;
				end else begin
					drop_inc = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_UPDATE: begin
				wr_en   = 1'b1;
				wr_data = (rd_data == COUNT_MAX) ? rd_data : rd_data + 1'b1;
				state_d = ST_IDLE;
			end
			ST_SCAN_RD: begin
				rd_en     = 1'b1;
				rd_addr   = scan_slot;
				addr_load = 1'b1;
				state_d   = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				if (rd_data != '0) begin
					// hold until the output register frees up
					if (out_free) begin
						out_load = 1'b1;
						wr_en    = 1'b1;
						scan_adv = 1'b1;
						state_d  = ST_IDLE;
					end
				end else if (scan_q == SLOT_LAST) begin
					if (out_free) begin
						out_load  = 1'b1;
						out_done  = 1'b1;
						scan_zero = 1'b1;
						state_d   = ST_IDLE;
					end
				end else begin
					scan_adv = 1'b1;
					state_d  = ST_SCAN_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			scan_q       <= '0;
			dropped_q    <= '0;
			out_valid_q  <= 1'b0;
			xy_scale_q   <= XY_SCALE_RESET;
			z_scale_q    <= Z_SCALE_RESET;
			order_mode_q <= ORDER_ZXY;
		end else begin
			state_q <= state_d;
			if (clr_adv) begin
				clr_q <= clr_q + 1'b1;
			end
			// wrap past the last slot falls out of the counter width
			if (scan_adv) begin
				scan_q <= scan_q + 1'b1;
			end else if (scan_zero) begin
				scan_q <= '0;
			end
			if (drop_inc && (dropped_q != COUNT_MAX)) begin
				dropped_q <= dropped_q + 1'b1;
			end else if (out_done) begin
				dropped_q <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_XY_SCALE:   xy_scale_q   <= cfg_data[SCALE_W-1:0];
					CFG_Z_SCALE:    z_scale_q    <= cfg_data[SCALE_W-1:0];
					CFG_ORDER_MODE: order_mode_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (addr_load) begin
			addr_q <= rd_addr;
		end
		if (out_load) begin
			out_done_q <= out_done;
			if (out_done) begin
				out_x_q     <= '0;
				out_y_q     <= '0;
				out_z_q     <= '0;
				out_count_q <= dropped_q;
			end else begin
				// back from offset binary to two's complement
				out_x_q <= addr_q[XY_INDEX_BITS +: XY_INDEX_BITS]
					^ {1'b1, {(XY_INDEX_BITS-1){1'b0}}};
				out_y_q <= addr_q[XY_INDEX_BITS-1:0]
					^ {1'b1, {(XY_INDEX_BITS-1){1'b0}}};
				out_z_q <= addr_q[GB-1 -: Z_INDEX_BITS]
					^ {1'b1, {(Z_INDEX_BITS-1){1'b0}}};
				out_count_q <= rd_data;
			end
		end
	end

	assign res_ch.valid       = out_valid_q;
	assign res_ch.x_index     = $signed(out_x_q);
	assign res_ch.y_index     = $signed(out_y_q);
	assign res_ch.z_index     = $signed(out_z_q);
	assign res_ch.point_count = out_count_q;
	assign res_ch.done_res    = out_done_q;

endmodule

FILE: design/vch_index.sv
// ----------------------------------------------------------------------------
// vch_index
// Coordinate to voxel digit: registered product, then truncation toward zero,
// window check and offset-binary digit.
// ----------------------------------------------------------------------------
module vch_index import vch_pkg::*; #(
	parameter int BITS = 5
) (
	input  logic                      clk,
	input  logic                      load,
	input  logic signed [COORD_W-1:0] coord,
	input  logic        [SCALE_W-1:0] scale,
	output logic        [BITS-1:0]    digit,
	output logic                      ok
);

	localparam int PW = COORD_W + SCALE_W + 1;
	localparam int QW = PW - INDEX_SHIFT;

	logic signed [PW-1:0] prod_s1;
	logic                 neg;
	logic        [PW-1:0] mag;
	logic        [QW-1:0] quot;
	logic        [QW-1:0] half;
	logic        [BITS-1:0] low;
	logic        [BITS-1:0] sval;

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= PW'(coord) * PW'($signed({1'b0, scale}));
		end
	end

	always_comb begin
		neg   = prod_s1[PW-1];
		mag   = neg ? PW'(-prod_s1) : PW'(prod_s1);
		quot  = mag[PW-1:INDEX_SHIFT];
		half  = QW'(1) << (BITS - 1);
		// negative side reaches -half, positive side stops at half-1
		ok    = neg ? (quot <= half) : (quot < half);
		low   = quot[BITS-1:0];
		sval  = neg ? BITS'(-low) : low;
		digit = {~sval[BITS-1], sval[BITS-2:0]};
	end

endmodule

FILE: design/vch_store.sv
// ----------------------------------------------------------------------------
// vch_store
// Voxel counter memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module vch_store #(
	parameter int AW = 15,
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem_q [2**AW];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// hold the last read word until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
